// ===== src/scfd_pkg.sv =====
// Shared constants and types for the serial command frame decoder.
// Depends on nothing; every other file of the block uses it.
package scfd_pkg;

    // Frame store geometry
    localparam int STORE_DEPTH = 18;
    localparam int BYTE_W      = 8;
    localparam int INDEX_W     = 8;
    localparam int ADDR_W      = 5;
    localparam int REPLY_W     = 3;
    localparam int FLAG_W      = 6;

    // Frame characters
    localparam logic [7:0] CH_TERM   = 8'h65; // 'e'
    localparam logic [7:0] CH_OPEN   = 8'h5B; // '['
    localparam logic [7:0] CH_CLOSE  = 8'h5D; // ']'
    localparam logic [7:0] CH_C      = 8'h43; // 'C'
    localparam logic [7:0] CH_R      = 8'h52; // 'R'
    localparam logic [7:0] CH_P      = 8'h50; // 'P'
    localparam logic [7:0] CH_A      = 8'h41; // 'A'
    localparam logic [7:0] CH_O      = 8'h4F; // 'O'
    localparam logic [7:0] CH_ZERO   = 8'h30; // '0'
    localparam logic [7:0] CH_ONE    = 8'h31; // '1'
    localparam logic [7:0] CH_TWO    = 8'h32; // '2'
    localparam logic [7:0] CH_THREE  = 8'h33; // '3'
    localparam logic [7:0] CH_FOUR   = 8'h34; // '4'
    localparam logic [7:0] CH_COMMA  = 8'h2C; // ','

    // Reply codes
    localparam logic [REPLY_W-1:0] REPLY_NONE    = 3'd0;
    localparam logic [REPLY_W-1:0] REPLY_REF_ONE = 3'd1;
    localparam logic [REPLY_W-1:0] REPLY_REF_TWO = 3'd2;
    localparam logic [REPLY_W-1:0] REPLY_LED_ERR = 3'd3;
    localparam logic [REPLY_W-1:0] REPLY_FAN_ERR = 3'd4;

    // Bit positions in the output flag word
    localparam int FLAG_LED1  = 0;
    localparam int FLAG_LED2  = 1;
    localparam int FLAG_BUZZ  = 2;
    localparam int FLAG_RELAY = 3;
    localparam int FLAG_FANA  = 4;
    localparam int FLAG_FANB  = 5;

    typedef logic [STORE_DEPTH-1:0][BYTE_W-1:0] frame_t;

    // Outcome of decoding one complete frame
    typedef struct packed {
        logic [REPLY_W-1:0] reply;
        logic [FLAG_W-1:0]  flags;
    } decode_result_t;

endpackage

// ===== src/scfd_if.sv =====
// Handshake channel interfaces for the serial command frame decoder:
// received bytes, result words and the address register write.
// Depends on scfd_pkg for field widths.
interface scfd_rx_if;
    logic                          valid;
    logic                          ready;
    logic [scfd_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfd_tx_if;
    logic                          valid;
    logic                          ready;
    logic [scfd_pkg::BYTE_W-1:0]   echo_byte;
    logic                          frame_end;
    logic [scfd_pkg::REPLY_W-1:0]  reply_code;
    logic                          led_one;
    logic                          led_two;
    logic                          buzzer_on;
    logic                          relay_on;
    logic                          fan_line_a;
    logic                          fan_line_b;

    modport source (output valid, output echo_byte, output frame_end, output reply_code,
                    output led_one, output led_two, output buzzer_on, output relay_on,
                    output fan_line_a, output fan_line_b, input ready);
    modport sink   (input valid, input echo_byte, input frame_end, input reply_code,
                    input led_one, input led_two, input buzzer_on, input relay_on,
                    input fan_line_a, input fan_line_b, output ready);
endinterface

interface scfd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [scfd_pkg::ADDR_W-1:0]   device_address;

    modport source (output valid, output device_address, input ready);
    modport sink   (input valid, input device_address, output ready);
endinterface

// ===== src/scfd_decode.sv =====
// Combinational decoder for one complete frame: address check, command
// recognition and the resulting reply code and output flag word.
// Depends on scfd_pkg.
module scfd_decode (
    input  scfd_pkg::frame_t                   frame,
    input  logic [scfd_pkg::ADDR_W-1:0]        device_address,
    input  logic [scfd_pkg::FLAG_W-1:0]        flags,
    output scfd_pkg::decode_result_t           result
);
    import scfd_pkg::*;

    logic       addr_ok;
    logic       cr_frame;
    logic       pa_frame;
    logic [7:0] action;
    logic [7:0] sel;

    // Positions 6 to 10 must hold '0' or '1' matching each address bit
    always_comb
    begin
        addr_ok = 1'b1;
        for (int b = 0; b < ADDR_W; b++)
        begin
            if (frame[6 + b] != (CH_ZERO | {7'd0, device_address[b]}))
            begin
                addr_ok = 1'b0;
            end
        end
    end

    // Frame shapes
    assign cr_frame = (frame[0] == CH_OPEN) && (frame[1] == CH_C) && (frame[2] == CH_R)
                   && (frame[3] == CH_COMMA) && (frame[5] == CH_COMMA)
                   && (frame[11] == CH_CLOSE);
    assign pa_frame = (frame[0] == CH_OPEN) && (frame[1] == CH_P) && (frame[2] == CH_A)
                   && (frame[3] == CH_COMMA) && (frame[5] == CH_COMMA)
                   && (frame[11] == CH_COMMA) && (frame[14] == CH_COMMA)
                   && (frame[17] == CH_CLOSE);

    assign action = frame[4];
    assign sel    = frame[12];

    // Command execution; device query frames fall through with no effect
    always_comb
    begin
        result.reply = REPLY_NONE;
        result.flags = flags;
        if (addr_ok)
        begin
            if (cr_frame)
            begin
                if (action == CH_ONE)
                begin
                    result.reply = REPLY_REF_ONE;
                end
                else if (action == CH_TWO)
                begin
                    result.reply = REPLY_REF_TWO;
                end
            end
            else if (pa_frame)
            begin
                case (action)
                    CH_ONE:
                    begin
                        if (sel == CH_ONE)
                        begin
                            result.flags[FLAG_LED1] = ~flags[FLAG_LED1];
                        end
                        else if (sel == CH_TWO)
                        begin
                            result.flags[FLAG_LED2] = ~flags[FLAG_LED2];
                        end
                        else
                        begin
                            result.reply = REPLY_LED_ERR;
                        end
                    end
                    CH_TWO:
                    begin
                        result.flags[FLAG_BUZZ] = ~flags[FLAG_BUZZ];
                    end
                    CH_THREE:
                    begin
                        if (sel == CH_ONE)
                        begin
                            result.flags[FLAG_FANA] = 1'b0;
                            result.flags[FLAG_FANB] = 1'b0;
                        end
                        else if (sel == CH_TWO)
                        begin
                            result.flags[FLAG_FANA] = 1'b1;
                            result.flags[FLAG_FANB] = 1'b0;
                        end
                        else if (sel == CH_THREE)
                        begin
                            result.flags[FLAG_FANA] = 1'b0;
                            result.flags[FLAG_FANB] = 1'b1;
                        end
                        else
                        begin
                            result.reply = REPLY_FAN_ERR;
                        end
                    end
                    CH_FOUR:
                    begin
                        result.flags[FLAG_RELAY] = ~flags[FLAG_RELAY];
                    end
                    default:
                    begin
                        result.flags = flags;
                    end
                endcase
            end
        end
    end

endmodule

// ===== src/serial_command_frame_decoder.sv =====
// Top level of the serial command frame decoder: input register, frame
// stores, output flags and result register. Depends on scfd_pkg,
// scfd_if.sv and scfd_decode.
//
// Usage:
//   rx carries one received byte per word. tx returns exactly one word per
//   received byte: the echoed byte, a frame end mark, a reply code and the
//   present state of the LED, buzzer, relay and fan outputs after it.
//   cfg writes the five-bit device address; it is always ready and must
//   only be written while no byte is in flight.
// Timing:
//   An accepted byte is registered in the input register; the store
//   update and frame decode then load its result word into the result
//   register once that register is empty or being taken. One byte is
//   accepted every cycle while tx holds ready high.
// Reset and stall:
//   Reset clears both frame stores, the byte index, the output flags and
//   the device address. When tx is stalled the result word holds, the
//   input register still takes one more byte, and rx then deasserts ready
//   until the result word is taken.
module serial_command_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    scfd_cfg_if.sink    cfg,
    scfd_rx_if.sink     rx,
    scfd_tx_if.source   tx
);
    import scfd_pkg::*;

    // Pipeline control
    logic                    s1_valid_reg;
    logic [BYTE_W-1:0]       s1_byte_reg;
    logic                    out_valid_reg;
    logic                    advance;

    // Block state
    logic [ADDR_W-1:0]       addr_reg;
    frame_t                  recv_reg;
    frame_t                  recv_next;
    frame_t                  dec_reg;
    frame_t                  frame_view;
    logic [INDEX_W-1:0]      index_reg;
    logic [INDEX_W-1:0]      index_next;
    logic [FLAG_W-1:0]       flags_reg;
    logic [FLAG_W-1:0]       flags_next;
    logic                    is_term;
    decode_result_t          dec_result;

    // Result register
    logic [BYTE_W-1:0]       echo_reg;
    logic                    end_reg;
    logic [REPLY_W-1:0]      reply_reg;
    logic [REPLY_W-1:0]      reply_next;

    assign advance  = s1_valid_reg && (!out_valid_reg || tx.ready);
    assign rx.ready = !s1_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign is_term  = (s1_byte_reg == CH_TERM);

    // Store the byte at the current index and form the frame as it
    // reads after the copy into the decode store
    always_comb
    begin
        recv_next = recv_reg;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (index_reg == INDEX_W'(i))
            begin
                recv_next[i] = s1_byte_reg;
            end
            frame_view[i] = (INDEX_W'(i) < index_reg) ? recv_reg[i] : dec_reg[i];
        end
    end

    scfd_decode u_decode (
        .frame          (frame_view),
        .device_address (addr_reg),
        .flags          (flags_reg),
        .result         (dec_result)
    );

    // Byte index, flags and reply for the byte being processed
    always_comb
    begin
        if (is_term)
        begin
            index_next = '0;
            flags_next = dec_result.flags;
            reply_next = dec_result.reply;
        end
        else
        begin
            index_next = (index_reg == {INDEX_W{1'b1}}) ? index_reg : index_reg + 1'b1;
            flags_next = flags_reg;
            reply_next = REPLY_NONE;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
            recv_reg      <= '0;
            dec_reg       <= '0;
            index_reg     <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                addr_reg <= cfg.device_address;
            end
            if (rx.valid && rx.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                recv_reg      <= recv_next;
                index_reg     <= index_next;
                flags_reg     <= flags_next;
                if (is_term)
                begin
                    dec_reg <= frame_view;
                end
            end
            else if (tx.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
        if (advance)
        begin
            echo_reg  <= s1_byte_reg;
            end_reg   <= is_term;
            reply_reg <= reply_next;
        end
    end

    // Result word; flags_reg already holds the state after this byte
    assign tx.valid      = out_valid_reg;
    assign tx.echo_byte  = echo_reg;
    assign tx.frame_end  = end_reg;
    assign tx.reply_code = reply_reg;
    assign tx.led_one    = flags_reg[FLAG_LED1];
    assign tx.led_two    = flags_reg[FLAG_LED2];
    assign tx.buzzer_on  = flags_reg[FLAG_BUZZ];
    assign tx.relay_on   = flags_reg[FLAG_RELAY];
    assign tx.fan_line_a = flags_reg[FLAG_FANA];
    assign tx.fan_line_b = flags_reg[FLAG_FANB];

endmodule
